// ===== rtl/led_strip_effect_generator_top_macros.svh =====
// Assertion macros shared by the LED strip effect generator RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
// No other dependencies.
`ifndef LED_STRIP_EFFECT_GENERATOR_TOP_MACROS_SVH
`define LED_STRIP_EFFECT_GENERATOR_TOP_MACROS_SVH

// Checks that a property holds at every clock edge out of reset.
`define LSEG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define LSEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lseg_pkg.sv =====
// Package for the LED strip effect generator: strip size, effect codes,
// constants and the frame context type. No dependencies.
`default_nettype none

package lseg_pkg;

  localparam int LedCount = 6;
  localparam int IdxW = (LedCount > 1) ? $clog2(LedCount) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(LedCount - 1);

  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] CfgEffect = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIntensity = 1'b1;

  localparam logic [2:0] EffectReset = 3'd0;
  localparam logic [6:0] IntensityReset = 7'd100;

  localparam logic [15:0] LfsrSeed = 16'hACE1;

  // Reciprocal for the spark position: x / LedCount == (x * SparkMul) >> SparkShift.
  localparam int SparkShift = 16 + $clog2(LedCount);
  localparam longint SparkMul = ((64'(1) << SparkShift) + LedCount - 1) / LedCount;

  localparam logic [7:0] LevelMax = 8'd255;

  typedef enum logic [2:0] {
    ModeChase   = 3'd0,
    ModeStars   = 3'd1,
    ModeRainbow = 3'd2,
    ModeBreathe = 3'd3,
    ModeStrobe  = 3'd4,
    ModeXmas    = 3'd5,
    ModeFlash   = 3'd6
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  phase;
    logic [4:0]  chase_red;
    logic [6:0]  level;
    logic [15:0] spark_a;
    logic [15:0] quot_a;
    logic [15:0] spark_b;
    logic [15:0] quot_b;
  } ctx_t;

endpackage

`default_nettype wire

// ===== rtl/lseg_if.sv =====
// Valid/ready channel interfaces for frame tick requests and LED colour requests.
// No dependencies.
`default_nettype none

interface lseg_in_if;
  logic valid;
  logic ready;
  logic white_flash;
  logic restart;

  modport source (output valid, output white_flash, output restart, input ready);
  modport sink (input valid, input white_flash, input restart, output ready);
endinterface

interface lseg_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_end;

  modport source (output valid, output led_index, output red, output green,
                  output blue, output frame_end, input ready);
  modport sink (input valid, input led_index, input red, input green,
                input blue, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/lseg_setup.sv =====
// Frame setup: holds phase and spark LFSR, builds the frame context for a tick.
// Depends on lseg_pkg.
`default_nettype none

module lseg_setup (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic             white_flash_i,
  input  wire logic             restart_i,
  input  wire logic [2:0]       effect_i,
  input  wire logic [6:0]       intensity_i,
  output lseg_pkg::ctx_t        ctx_o
);
  import lseg_pkg::*;

  localparam logic [15:0] LfsrTaps = 16'hB400;
  localparam logic [7:0] RainbowStep = 8'd5;
  localparam logic [7:0] BreatheStep = 8'd10;
  localparam logic [6:0] IntensityMax = 7'd100;
  localparam logic [9:0] ChaseMul = 10'd984;
  localparam logic [15:0] LevelMul = 16'd51604;

  logic [7:0]  phase_q, phase_d;
  logic [15:0] lfsr_q, lfsr_d;
  logic [7:0]  ph0, ph_inc, bre_a;
  logic [15:0] lf0, lf1, lf2, lf3;
  logic [6:0]  pct;
  logic [32:0] prod_a, prod_b;
  logic [16:0] chase_prod;
  logic [22:0] level_prod;
  mode_e       eff_mode;

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LfsrTaps;
    end
    return (n == 16'd0) ? LfsrSeed : n;
  endfunction

  always_comb begin
    ph0 = restart_i ? 8'd0 : phase_q;
    lf0 = restart_i ? LfsrSeed : lfsr_q;
    lf1 = lfsr_step(lf0);
    lf2 = lfsr_step(lf1);
    lf3 = lfsr_step(lf2);
    ph_inc = ph0 + 8'd1;

    unique case (effect_i)
      3'd1:    eff_mode = ModeStars;
      3'd2:    eff_mode = ModeRainbow;
      3'd3:    eff_mode = ModeBreathe;
      3'd4:    eff_mode = ModeStrobe;
      3'd5:    eff_mode = ModeXmas;
      default: eff_mode = ModeChase;
    endcase

    phase_d = ph0;
    lfsr_d = lf0;
    if (!white_flash_i) begin
      unique case (eff_mode)
        ModeStars:   lfsr_d = lf3;
        ModeRainbow: phase_d = ph0 + RainbowStep;
        ModeBreathe: phase_d = ph0 + BreatheStep;
        ModeStrobe:  phase_d = ph_inc;
        ModeXmas:    phase_d = ph_inc;
        default:     phase_d = (ph_inc >= 8'(LedCount)) ? 8'd0 : ph_inc;
      endcase
    end

    pct = (intensity_i > IntensityMax) ? IntensityMax : intensity_i;
    chase_prod = 17'(pct) * 17'(ChaseMul);
    bre_a = ph0[7] ? (LevelMax - ph0) : ph0;
    level_prod = 23'(bre_a[6:0]) * 23'(LevelMul);
    prod_a = 33'(lf2) * 33'(SparkMul);
    prod_b = 33'(lf3) * 33'(SparkMul);

    ctx_o.mode = white_flash_i ? ModeFlash : eff_mode;
    ctx_o.phase = ph0;
    ctx_o.chase_red = 5'(chase_prod >> 12);
    ctx_o.level = 7'(level_prod >> 16);
    ctx_o.spark_a = lf2;
    ctx_o.quot_a = 16'(prod_a >> SparkShift);
    ctx_o.spark_b = lf3;
    ctx_o.quot_b = 16'(prod_b >> SparkShift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 8'd0;
      lfsr_q <= LfsrSeed;
    end else if (accept_i) begin
      phase_q <= phase_d;
      lfsr_q <= lfsr_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lseg_emit.sv =====
// LED emitter: holds the frame context, walks the LEDs and drives the output register.
// Depends on lseg_pkg, lseg_if and the assertion macro header.
`default_nettype none
`include "led_strip_effect_generator_top_macros.svh"

module lseg_emit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           tick_valid_i,
  output logic                tick_ready_o,
  input  wire lseg_pkg::ctx_t ctx_i,
  lseg_out_if.source          pix_o
);
  import lseg_pkg::*;

  localparam logic [7:0] WheelStep = 8'd42;
  localparam logic [7:0] ChaseMax = 8'd24;
  localparam logic [7:0] SparkRedLo = 8'd80;
  localparam logic [7:0] SparkGreenLo = 8'd120;
  localparam logic [15:0] GreenMul = 16'd820;
  localparam logic [24:0] BlueMul = 25'd167127;

  ctx_t            ctx_q;
  logic            ctx_valid_q;
  logic [IdxW-1:0] cnt_q;
  logic            out_valid_q;
  logic [2:0]      out_idx_q;
  logic [7:0]      out_r_q, out_g_q, out_b_q;
  logic            out_end_q;

  logic            advance, last, accept;
  logic [7:0]      r_d, g_d, b_d, wpos;
  logic [15:0]     pos_a, pos_b;
  logic [16:0]     green_prod;
  logic [24:0]     blue_prod;

  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] t;
    logic [23:0] rgb;
    if (pos < 8'd85) begin
      t = 8'(pos * 8'd3);
      rgb = {LevelMax - t, t, 8'd0};
    end else if (pos < 8'd170) begin
      p = pos - 8'd85;
      t = 8'(p * 8'd3);
      rgb = {8'd0, LevelMax - t, t};
    end else begin
      p = pos - 8'd170;
      t = 8'(p * 8'd3);
      rgb = {t, 8'd0, LevelMax - t};
    end
    return rgb;
  endfunction

  assign last = (cnt_q == LastIdx);
  assign advance = ctx_valid_q && (!out_valid_q || pix_o.ready);
  assign tick_ready_o = !ctx_valid_q || (advance && last);
  assign accept = tick_valid_i && tick_ready_o;

  always_comb begin
    r_d = 8'd0;
    g_d = 8'd0;
    b_d = 8'd0;
    wpos = ctx_q.phase + 8'(8'(cnt_q) * WheelStep);
    pos_a = ctx_q.spark_a - 16'(ctx_q.quot_a * 16'(LedCount));
    pos_b = ctx_q.spark_b - 16'(ctx_q.quot_b * 16'(LedCount));
    green_prod = 17'(ctx_q.level) * 17'(GreenMul);
    blue_prod = 25'(ctx_q.level) * BlueMul;
    unique case (ctx_q.mode)
      ModeFlash: begin
        r_d = LevelMax;
        g_d = LevelMax;
        b_d = LevelMax;
      end
      ModeChase: begin
        if (8'(cnt_q) == ctx_q.phase) begin
          r_d = 8'(ctx_q.chase_red);
          b_d = ChaseMax - 8'(ctx_q.chase_red);
        end
      end
      ModeStars: begin
        priority if (pos_b[IdxW-1:0] == cnt_q) begin
          r_d = ctx_q.spark_b[3] ? LevelMax : SparkRedLo;
          g_d = ctx_q.spark_b[4] ? LevelMax : SparkGreenLo;
          b_d = LevelMax;
        end else if (pos_a[IdxW-1:0] == cnt_q) begin
          r_d = ctx_q.spark_a[3] ? LevelMax : SparkRedLo;
          g_d = ctx_q.spark_a[4] ? LevelMax : SparkGreenLo;
          b_d = LevelMax;
        end else begin
          r_d = 8'd0;
        end
      end
      ModeRainbow: {r_d, g_d, b_d} = wheel(wpos);
      ModeBreathe: begin
        g_d = 8'(green_prod >> 10);
        b_d = 8'(blue_prod >> 16);
      end
      ModeStrobe: begin
        if (!ctx_q.phase[0]) begin
          r_d = LevelMax;
          g_d = LevelMax;
          b_d = LevelMax;
        end
      end
      ModeXmas: begin
        if (cnt_q[0] ^ ctx_q.phase[0]) begin
          g_d = LevelMax;
        end else begin
          r_d = LevelMax;
        end
      end
      default: begin
        r_d = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_valid_q <= 1'b0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        ctx_valid_q <= 1'b1;
      end else if (advance && last) begin
        ctx_valid_q <= 1'b0;
      end
      if (advance) begin
        cnt_q <= last ? '0 : cnt_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctx_q <= ctx_i;
    end
    if (advance) begin
      out_idx_q <= 3'(cnt_q);
      out_r_q <= r_d;
      out_g_q <= g_d;
      out_b_q <= b_d;
      out_end_q <= last;
    end
  end

  assign pix_o.valid = out_valid_q;
  assign pix_o.led_index = out_idx_q;
  assign pix_o.red = out_r_q;
  assign pix_o.green = out_g_q;
  assign pix_o.blue = out_b_q;
  assign pix_o.frame_end = out_end_q;

  `LSEG_ASSERT(a_cnt_range, cnt_q <= LastIdx, "LED counter out of range")
  `LSEG_ASSERT(a_cnt_ctx, (cnt_q != '0) |-> ctx_valid_q, "LED counter moved without a frame")
  `LSEG_ASSERT(a_end_idx, (out_valid_q && out_end_q) |-> (out_idx_q == 3'(LastIdx)), "Frame end on wrong LED")
  `LSEG_ASSERT_NEXT(a_accept_ctx, accept, ctx_valid_q, "Accepted tick left no frame context")

endmodule

`default_nettype wire

// ===== rtl/led_strip_effect_generator_top.sv =====
// Channel     | Dir | Payload
// tick_i      | in  | white_flash, restart
// pix_o       | out | led_index, red, green, blue, frame_end
// cfg port    | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i (effect, intensity)
// A tick yields LedCount LED requests: the emitter sends one per cycle while the output is not stalled.
// The next tick is taken at the edge that loads the current frame's last LED for output.
// The first LED of a tick is computed from the registered frame context, then loaded into the output register.
// Reset sets effect to chase, intensity to 100, phase to 0 and the LFSR to its seed.
// A stalled output holds its request and stops the LED walk until taken.
//
// Top level of the LED strip effect generator: configuration registers and wiring.
// Depends on lseg_pkg, lseg_if, lseg_setup and lseg_emit.
`default_nettype none

module led_strip_effect_generator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lseg_in_if.sink                            tick_i,
  lseg_out_if.source                         pix_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lseg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lseg_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import lseg_pkg::*;

  logic [2:0] effect_q;
  logic [6:0] intensity_q;
  logic       tick_accept;
  logic       tick_ready;
  ctx_t       ctx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_q <= EffectReset;
      intensity_q <= IntensityReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEffect:    effect_q <= cfg_wdata_i[2:0];
        CfgIntensity: intensity_q <= cfg_wdata_i[6:0];
        default:      effect_q <= effect_q;
      endcase
    end
  end

  assign tick_i.ready = tick_ready;
  assign tick_accept = tick_i.valid && tick_ready;

  lseg_setup u_setup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (tick_accept),
    .white_flash_i (tick_i.white_flash),
    .restart_i     (tick_i.restart),
    .effect_i      (effect_q),
    .intensity_i   (intensity_q),
    .ctx_o         (ctx)
  );

  lseg_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (tick_i.valid),
    .tick_ready_o (tick_ready),
    .ctx_i        (ctx),
    .pix_o        (pix_o)
  );

endmodule

`default_nettype wire
